// File: design/pde_pkg.sv
// shared types, constants and decode helpers for the postfix digit evaluator
// no dependencies; imported by the arithmetic unit, the top level and the checker
`timescale 1ns / 1ps

package pde_pkg;

  // stack geometry
  localparam int STACK_DEPTH = 128;
  localparam int ADDR_W      = $clog2(STACK_DEPTH);
  localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
  localparam int CMP_W       = (CNT_W > 8) ? CNT_W : 8;

  // stack limit after reset
  localparam logic [7:0] LIMIT_RESET = 8'd100;

  // character codes
  localparam logic [7:0] CH_END   = 8'd0;
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_TIMES = 8'd42;
  localparam logic [7:0] CH_SLASH = 8'd47;

  // offsets used by the arithmetic unit
  localparam logic [9:0] OFS_ZERO = 10'd48;
  localparam logic [9:0] OFS_ADD  = 10'd208;

  typedef enum logic [1:0] {
    OP_ADD,
    OP_SUB,
    OP_MUL,
    OP_DIV
  } op_t;

  // main sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_POP_A,
    ST_POP_B,
    ST_START,
    ST_CALC,
    ST_REPORT
  } seq_state_t;

  // arithmetic unit states
  typedef enum logic [1:0] {
    AL_IDLE,
    AL_MUL,
    AL_DIV,
    AL_FIN
  } alu_state_t;

  typedef struct packed {
    logic       start;
    op_t        op;
    logic [7:0] left;
    logic [7:0] right;
  } alu_req_t;

  typedef struct packed {
    logic       done;
    logic [7:0] result;
    logic       div_zero;
  } alu_rsp_t;

  function automatic logic is_digit(input logic [7:0] s);
    return (s >= CH_ZERO) && (s <= CH_NINE);
  endfunction

  function automatic logic is_oper(input logic [7:0] s);
    return (s == CH_PLUS) || (s == CH_MINUS) || (s == CH_TIMES) || (s == CH_SLASH);
  endfunction

endpackage

// File: design/pde_if.sv
// valid/ready channel interfaces for the symbol input and the result output
// depends on nothing but plain logic types
`timescale 1ns / 1ps

interface pde_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;

  modport source (output valid, output symbol, input ready);
  modport sink   (input valid, input symbol, output ready);
endinterface

interface pde_out_if;
  logic              valid;
  logic              ready;
  logic signed [8:0] result_value;
  logic              underflow_seen;
  logic              overflow_seen;
  logic              divide_by_zero_seen;
  logic [7:0]        entries_left;

  modport source (output valid, output result_value, output underflow_seen,
                  output overflow_seen, output divide_by_zero_seen,
                  output entries_left, input ready);
  modport sink   (input valid, input result_value, input underflow_seen,
                  input overflow_seen, input divide_by_zero_seen,
                  input entries_left, output ready);
endinterface

// File: design/pde_alu.sv
// iterative arithmetic unit: one shared 10-bit adder does add, subtract,
// shift-add multiply and restoring divide; depends on pde_pkg
`timescale 1ns / 1ps

module pde_alu (
  input  logic              clk,
  input  logic              rst_n,
  input  pde_pkg::alu_req_t req,
  output pde_pkg::alu_rsp_t rsp
);
  import pde_pkg::*;

  alu_state_t state_r, state_nxt;
  op_t        op_r;
  logic [7:0] acc_r;
  logic [7:0] mcand_r;
  logic [7:0] mplier_r;
  logic [8:0] rem_r;
  logic [2:0] cnt_r;
  logic       neg_r;
  logic       divz_r;

  logic signed [8:0] lval, rval;
  logic [8:0]        lneg, rneg;
  logic [7:0]        lmag, rmag;
  logic [8:0]        rem_sh;
  logic [9:0]        add_a, add_b, add_sum;
  logic              add_sub;

  // operand values: byte minus the digit offset, and their magnitudes
  always_comb begin
    lval = $signed({req.left[7], req.left}) - 9'sd48;
    rval = $signed({req.right[7], req.right}) - 9'sd48;
    lneg = 9'd0 - lval;
    rneg = 9'd0 - rval;
    lmag = lval[8] ? lneg[7:0] : lval[7:0];
    rmag = rval[8] ? rneg[7:0] : rval[7:0];
  end

  assign rem_sh = {rem_r[7:0], mplier_r[7]};

  // operand select for the shared adder
  always_comb begin
    add_a   = {2'b00, acc_r};
    add_b   = {2'b00, mcand_r};
    add_sub = 1'b0;
    unique case (state_r)
      AL_IDLE: begin
        add_a   = {2'b00, req.left};
        add_b   = {2'b00, req.right};
        add_sub = (req.op == OP_SUB);
      end
      AL_MUL: begin
        add_a   = {2'b00, acc_r};
        add_b   = {2'b00, mcand_r};
        add_sub = 1'b0;
      end
      AL_DIV: begin
        add_a   = {1'b0, rem_sh};
        add_b   = {2'b00, mcand_r};
        add_sub = 1'b1;
      end
      AL_FIN: begin
        if (op_r == OP_DIV && !divz_r) begin
          add_a   = OFS_ZERO;
          add_b   = {2'b00, mplier_r};
          add_sub = neg_r;
        end else begin
          add_a   = {2'b00, acc_r};
          add_b   = (op_r == OP_ADD) ? OFS_ADD : OFS_ZERO;
          add_sub = 1'b0;
        end
      end
    endcase
  end

  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {9'd0, add_sub};

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      AL_IDLE: begin
        if (req.start) begin
          unique case (req.op)
            OP_ADD, OP_SUB: state_nxt = AL_FIN;
            OP_MUL:         state_nxt = AL_MUL;
            OP_DIV:         state_nxt = (rval == 9'sd0) ? AL_FIN : AL_DIV;
          endcase
        end
      end
      AL_MUL:  state_nxt = (cnt_r == 3'd0) ? AL_FIN : AL_MUL;
      AL_DIV:  state_nxt = (cnt_r == 3'd0) ? AL_FIN : AL_DIV;
      AL_FIN:  state_nxt = AL_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    rsp.done     = (state_r == AL_FIN);
    rsp.result   = add_sum[7:0];
    rsp.div_zero = divz_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= AL_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state_r)
      AL_IDLE: begin
        if (req.start) begin
          op_r   <= req.op;
          cnt_r  <= 3'd7;
          divz_r <= 1'b0;
          neg_r  <= lval[8] ^ rval[8];
          unique case (req.op)
            OP_ADD, OP_SUB: begin
              acc_r <= add_sum[7:0];
            end
            OP_MUL: begin
              acc_r    <= 8'd0;
              mcand_r  <= lval[7:0];
              mplier_r <= rval[7:0];
            end
            OP_DIV: begin
              rem_r    <= 9'd0;
              mplier_r <= lmag;
              mcand_r  <= rmag;
              if (rval == 9'sd0) begin
                divz_r <= 1'b1;
                acc_r  <= 8'hFF;
              end
            end
          endcase
        end
      end
      // shift-add multiply, product kept modulo 256
      AL_MUL: begin
        if (mplier_r[0]) begin
          acc_r <= add_sum[7:0];
        end
        mcand_r  <= {mcand_r[6:0], 1'b0};
        mplier_r <= {1'b0, mplier_r[7:1]};
        cnt_r    <= cnt_r - 3'd1;
      end
      // restoring divide, one quotient bit per cycle
      AL_DIV: begin
        if (!add_sum[9]) begin
          rem_r    <= add_sum[8:0];
          mplier_r <= {mplier_r[6:0], 1'b1};
        end else begin
          rem_r    <= rem_sh;
          mplier_r <= {mplier_r[6:0], 1'b0};
        end
        cnt_r <= cnt_r - 3'd1;
      end
      AL_FIN: begin
      end
    endcase
  end

endmodule

// File: design/postfix_digit_evaluator.sv
// A digit or ignored symbol is handled in ST_IDLE without leaving it; an operator
// runs ST_POP_A, ST_POP_B, ST_START and ST_CALC, where * and / loop through the
// 8 passes of the shared adder and a / by a zero divisor skips the passes.
// An end symbol runs ST_POP_A and ST_REPORT, which holds while the output is held.
// ready is low while an item is at work, so a new item waits for the last one.
// Reset (rst_n low, synchronous): stack empty, flags clear, limit 100, no result
// pending; stack contents stay undefined and are never read before written.
`timescale 1ns / 1ps

// top level: stack sequencer, stack memory and result register
// depends on pde_pkg, pde_if and pde_alu

module postfix_digit_evaluator (
  input  logic       clk,
  input  logic       rst_n,
  pde_in_if.sink     in_ch,
  pde_out_if.source  out_ch,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);
  import pde_pkg::*;

  seq_state_t       state_r, state_nxt;
  logic [7:0]       limit_r;
  logic [CNT_W-1:0] count_r;
  logic             under_r, over_r, divz_r;
  op_t              op_r;
  logic             is_end_r;
  logic             empty_a_r, empty_b_r;
  logic [7:0]       opa_r;
  logic [7:0]       rdata_r;
  logic [7:0]       stack_mem [STACK_DEPTH];

  logic              out_valid_r;
  logic signed [8:0] res_value_r;
  logic              res_under_r, res_over_r, res_divz_r;
  logic [7:0]        res_entries_r;

  logic             accept;
  logic             sym_digit, sym_oper, sym_end;
  logic [CMP_W-1:0] eff_limit, lim_ext, depth_ext;
  logic             full, empty;
  logic [CNT_W-1:0] count_dec;
  logic             pop_now, push_req, mem_we, out_load;
  logic [7:0]       push_data;
  logic [7:0]       pop_byte;
  alu_req_t         alu_req;
  alu_rsp_t         alu_rsp;

  function automatic op_t decode_op(input logic [7:0] s);
    op_t o;
    o = OP_DIV;
    priority if (s == CH_PLUS)  o = OP_ADD;
    else if (s == CH_MINUS)     o = OP_SUB;
    else if (s == CH_TIMES)     o = OP_MUL;
    else                        o = OP_DIV;
    return o;
  endfunction

  // symbol decode
  assign accept    = in_ch.valid && in_ch.ready;
  assign sym_digit = is_digit(in_ch.symbol);
  assign sym_oper  = is_oper(in_ch.symbol);
  assign sym_end   = (in_ch.symbol == CH_END);

  // stack limit saturates at the stack depth
  always_comb begin
    lim_ext   = CMP_W'(limit_r);
    depth_ext = CMP_W'(STACK_DEPTH);
    eff_limit = (lim_ext > depth_ext) ? depth_ext : lim_ext;
  end

  assign full      = CMP_W'(count_r) >= eff_limit;
  assign empty     = (count_r == '0);
  assign count_dec = count_r - CNT_W'(1);
  assign pop_byte  = empty_a_r ? 8'd0 : rdata_r;

  // next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (sym_end || sym_oper)) begin
          state_nxt = ST_POP_A;
        end
      end
      ST_POP_A:  state_nxt = is_end_r ? ST_REPORT : ST_POP_B;
      ST_POP_B:  state_nxt = ST_START;
      ST_START:  state_nxt = ST_CALC;
      ST_CALC:   state_nxt = alu_rsp.done ? ST_IDLE : ST_CALC;
      ST_REPORT: state_nxt = (!out_valid_r || out_ch.ready) ? ST_IDLE : ST_REPORT;
    endcase
  end

  // control outputs of the sequencer
  always_comb begin
    in_ch.ready   = (state_r == ST_IDLE);
    pop_now       = (state_r == ST_POP_A) || (state_r == ST_POP_B);
    push_req      = 1'b0;
    push_data     = in_ch.symbol;
    out_load      = (state_r == ST_REPORT) && (!out_valid_r || out_ch.ready);
    alu_req.start = (state_r == ST_START);
    alu_req.op    = op_r;
    alu_req.left  = empty_b_r ? 8'd0 : rdata_r;
    alu_req.right = opa_r;
    if (state_r == ST_IDLE && accept && sym_digit) begin
      push_req  = 1'b1;
      push_data = in_ch.symbol;
    end else if (state_r == ST_CALC && alu_rsp.done) begin
      push_req  = 1'b1;
      push_data = alu_rsp.result;
    end
  end

  assign mem_we = push_req && !full;

  pde_alu u_alu (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (alu_req),
    .rsp   (alu_rsp)
  );

  // stack memory, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[count_r[ADDR_W-1:0]] <= push_data;
    end
    if (pop_now && !empty) begin
      rdata_r <= stack_mem[count_dec[ADDR_W-1:0]];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      limit_r     <= LIMIT_RESET;
      count_r     <= '0;
      under_r     <= 1'b0;
      over_r      <= 1'b0;
      divz_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        limit_r <= cfg_wdata;
      end
      // stack count and sticky flags
      if (out_load) begin
        count_r <= '0;
        under_r <= 1'b0;
        over_r  <= 1'b0;
        divz_r  <= 1'b0;
      end else begin
        if (pop_now) begin
          if (empty) begin
            under_r <= 1'b1;
          end else begin
            count_r <= count_dec;
          end
        end else if (push_req) begin
          if (full) begin
            over_r <= 1'b1;
          end else begin
            count_r <= count_r + CNT_W'(1);
          end
        end
        if (state_r == ST_CALC && alu_rsp.done && alu_rsp.div_zero) begin
          divz_r <= 1'b1;
        end
      end
      // result handshake
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // item payload and popped operands
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r     <= decode_op(in_ch.symbol);
      is_end_r <= sym_end;
    end
    if (state_r == ST_POP_A) begin
      empty_a_r <= empty;
    end
    if (state_r == ST_POP_B) begin
      opa_r     <= pop_byte;
      empty_b_r <= empty;
    end
    if (out_load) begin
      res_value_r   <= $signed({pop_byte[7], pop_byte}) - 9'sd48;
      res_under_r   <= under_r;
      res_over_r    <= over_r;
      res_divz_r    <= divz_r;
      res_entries_r <= 8'(count_r);
    end
  end

  // result channel
  always_comb begin
    out_ch.valid               = out_valid_r;
    out_ch.result_value        = res_value_r;
    out_ch.underflow_seen      = res_under_r;
    out_ch.overflow_seen       = res_over_r;
    out_ch.divide_by_zero_seen = res_divz_r;
    out_ch.entries_left        = res_entries_r;
  end

endmodule

// File: design/pde_checker.sv
// port-level checks on the postfix digit evaluator, bound to the top level
// depends on pde_pkg and on the top level's channel ports
`timescale 1ns / 1ps

module pde_checker (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic [7:0]        in_symbol,
  input logic              out_valid,
  input logic              out_ready,
  input logic signed [8:0] out_value,
  input logic [7:0]        out_entries
);
  import pde_pkg::*;

  logic in_acc;
  logic in_work;

  assign in_acc  = in_valid && in_ready;
  assign in_work = (in_symbol == CH_END) || is_oper(in_symbol);

  // a held result keeps its payload until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_value) && $stable(out_entries))
    else $error("result item changed before it was taken");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // operators and end symbols keep the block busy in the next cycle
  a_busy_after_work: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_work |=> !in_ready)
    else $error("ready right after an operator or end item");

  // a digit or ignored symbol leaves the block ready again in the next cycle
  a_ready_after_push: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && !in_work |=> in_ready)
    else $error("not ready after a one-cycle item");

endmodule

bind postfix_digit_evaluator pde_checker u_pde_checker (
  .clk         (clk),
  .rst_n       (rst_n),
  .in_valid    (in_ch.valid),
  .in_ready    (in_ch.ready),
  .in_symbol   (in_ch.symbol),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .out_value   (out_ch.result_value),
  .out_entries (out_ch.entries_left)
);

// File: tb/sv/pde_result_checker.sv
// result checker for the postfix digit evaluator: follows the symbol, result
// and limit ports, keeps its own stack and compares every result it sees
// depends on pde_pkg and the pde_in_if / pde_out_if interfaces
`timescale 1ns / 1ps

module pde_result_checker (
  input  logic       clk,
  input  logic       rst_n,
  pde_in_if          in_mon,
  pde_out_if         out_mon,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output int         mismatch_count,
  output int         pending_results,
  output int         results_checked,
  output logic [2:0] flags_hit
);
  import pde_pkg::*;

  localparam int MAX_REPORTS = 10;

  typedef struct packed {
    logic signed [8:0] value;
    logic              under;
    logic              over;
    logic              divz;
    logic [7:0]        left;
  } expr_outcome_t;

  // shadow of the evaluator state
  logic [7:0]    stack_mem [STACK_DEPTH];
  int            depth = 0;
  logic          under_f;
  logic          over_f;
  logic          divz_f;
  logic [7:0]    limit_reg = LIMIT_RESET;
  expr_outcome_t outcome_q[$];

  int         errors = 0;
  int         checked = 0;
  logic [2:0] seen = '0;

  // entry value as the arithmetic sees it: signed byte minus the zero code
  function automatic int operand(input logic [7:0] b);
    return int'($signed(b)) - int'(CH_ZERO);
  endfunction

  // empty stack gives entry zero and marks underflow
  function automatic logic [7:0] pop_entry();
    if (depth == 0) begin
      under_f = 1'b1;
      return 8'h00;
    end
    depth--;
    return stack_mem[depth];
  endfunction

  // push is dropped once the capped limit is reached
  function automatic void push_entry(input logic [7:0] b);
    int cap;
    cap = (int'(limit_reg) > STACK_DEPTH) ? STACK_DEPTH : int'(limit_reg);
    if (depth >= cap) begin
      over_f = 1'b1;
      return;
    end
    stack_mem[depth] = b;
    depth++;
  endfunction

  // two pops (right first), combine, push back with the zero code added
  function automatic void combine(input logic [7:0] op);
    int rhs;
    int lhs;
    int res;
    rhs = operand(pop_entry());
    lhs = operand(pop_entry());
    if (op == CH_PLUS) begin
      res = lhs + rhs;
    end else if (op == CH_MINUS) begin
      res = lhs - rhs;
    end else if (op == CH_TIMES) begin
      res = lhs * rhs;
    end else if (rhs == 0) begin
      divz_f = 1'b1;
      res    = -1;
    end else begin
      res = lhs / rhs;
    end
    push_entry(8'(res + int'(CH_ZERO)));
  endfunction

  // one accepted symbol; only the end symbol yields a result
  function automatic void predict_symbol(input logic [7:0] s);
    expr_outcome_t o;
    if (s == CH_END) begin
      o.value = 9'(operand(pop_entry()));
      o.under = under_f;
      o.over  = over_f;
      o.divz  = divz_f;
      o.left  = 8'(depth);
      outcome_q.push_back(o);
      depth   = 0;
      under_f = 1'b0;
      over_f  = 1'b0;
      divz_f  = 1'b0;
    end else if (s >= CH_ZERO && s <= CH_NINE) begin
      push_entry(s);
    end else if (s == CH_PLUS || s == CH_MINUS || s == CH_TIMES || s == CH_SLASH) begin
      combine(s);
    end
  endfunction

  // compare one accepted result against the oldest expectation
  task automatic check_result();
    expr_outcome_t got;
    expr_outcome_t want;
    got.value = out_mon.result_value;
    got.under = out_mon.underflow_seen;
    got.over  = out_mon.overflow_seen;
    got.divz  = out_mon.divide_by_zero_seen;
    got.left  = out_mon.entries_left;
    if (outcome_q.size() == 0) begin
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] unexpected result: value %0d flags u%b o%b d%b left %0d",
                 $realtime, got.value, got.under, got.over, got.divz, got.left);
    end else begin
      want = outcome_q.pop_front();
      checked++;
      seen = seen | {want.divz, want.over, want.under};
      if (got.value !== want.value || got.under !== want.under ||
          got.over !== want.over || got.divz !== want.divz || got.left !== want.left) begin
        errors++;
        if (errors <= MAX_REPORTS)
          $display("[%0t] result %0d mismatch: exp value %0d u%b o%b d%b left %0d,",
                   $realtime, checked, want.value, want.under, want.over, want.divz,
                   want.left, " got value %0d u%b o%b d%b left %0d",
                   got.value, got.under, got.over, got.divz, got.left);
      end
    end
  endtask

  // sample on the rising edge, everything the driver set before it
  always @(posedge clk) begin
    if (!rst_n) begin
      depth     = 0;
      under_f   = 1'b0;
      over_f    = 1'b0;
      divz_f    = 1'b0;
      limit_reg = LIMIT_RESET;
      outcome_q.delete();
    end else begin
      if (cfg_we)
        limit_reg = cfg_wdata;
      if (in_mon.valid && in_mon.ready)
        predict_symbol(in_mon.symbol);
      if (out_mon.valid && out_mon.ready)
        check_result();
    end
    mismatch_count  <= errors;
    pending_results <= outcome_q.size();
    results_checked <= checked;
    flags_hit       <= seen;
  end

endmodule

// File: tb/sv/tb_postfix_digit_evaluator.sv
// testbench top for the postfix digit evaluator: clock, reset, symbol and
// limit stimulus, result-side flow control and the final verdict
// depends on pde_pkg, pde_if, postfix_digit_evaluator and pde_result_checker
`timescale 1ns / 1ps

module tb_postfix_digit_evaluator;
  import pde_pkg::*;

  localparam int    HALF_PERIOD   = 5;
  localparam int    RESET_CYCLES  = 3;
  localparam int    IDLE_PCT      = 6;
  localparam int    SETTLE_CYCLES = 20;
  localparam int    HOLD_CYCLES   = 300;
  localparam int    DEEP_OPERANDS = 130;
  localparam longint TIMEOUT_NS   = 5_000_000;

  localparam logic [7:0] SYM_TOP_BYTE = 8'hFF;
  localparam logic [7:0] SYM_LOW_BYTE = 8'h01;

  logic       clk = 1'b0;
  logic       rst_n;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  int         mismatch_count;
  int         pending_results;
  int         results_checked;
  logic [2:0] flags_hit;

  bit         no_idle;
  int         hold_asks;
  int         hold_served;
  int         hold_left;
  int         symbols_sent;
  int         limits_applied;
  logic [7:0] expr_q[$];

  pde_in_if  in_ch ();
  pde_out_if out_ch ();

  postfix_digit_evaluator u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  pde_result_checker u_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_mon          (in_ch),
    .out_mon         (out_ch),
    .cfg_we          (cfg_we),
    .cfg_wdata       (cfg_wdata),
    .mismatch_count  (mismatch_count),
    .pending_results (pending_results),
    .results_checked (results_checked),
    .flags_hit       (flags_hit)
  );

  // clock
  always #(HALF_PERIOD) clk = ~clk;

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("timeout with %0d results still outstanding", pending_results);
    $display("tb_postfix_digit_evaluator: done, errors");
    $finish;
  end

  // result side: random stalls plus a requested long hold-off
  initial begin
    out_ch.ready = 1'b0;
    hold_served  = 0;
    hold_left    = 0;
    forever begin
      @(posedge clk);
      if (hold_left == 0 && hold_served != hold_asks) begin
        hold_left = HOLD_CYCLES;
        hold_served++;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_ch.ready <= 1'b0;
      end else begin
        out_ch.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  function automatic logic [7:0] digit(input int k);
    return CH_ZERO + 8'(k);
  endfunction

  function automatic logic [7:0] rand_oper();
    case ($urandom_range(0, 3))
      0:       return CH_PLUS;
      1:       return CH_MINUS;
      2:       return CH_TIMES;
      default: return CH_SLASH;
    endcase
  endfunction

  // any nonzero code the evaluator skips
  function automatic logic [7:0] rand_ignored();
    logic [7:0] s;
    do
      s = 8'($urandom_range(1, 255));
    while ((s >= CH_ZERO && s <= CH_NINE) || s == CH_PLUS || s == CH_MINUS ||
           s == CH_TIMES || s == CH_SLASH);
    return s;
  endfunction

  // offer one item and hold it until accepted
  task automatic push_symbol(input logic [7:0] sym);
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid  <= 1'b1;
    in_ch.symbol <= sym;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    symbols_sent++;
  endtask

  task automatic send_expr();
    foreach (expr_q[i]) push_symbol(expr_q[i]);
  endtask

  // valid postfix with random digits and operators; deep pushes all digits first
  task automatic build_wellformed(input int operands, input bit deep);
    int stack_est;
    int remaining;
    expr_q.delete();
    stack_est = 0;
    remaining = operands;
    while (remaining > 0 || stack_est > 1) begin
      if (!deep && $urandom_range(0, 99) < 4)
        expr_q.push_back(rand_ignored());
      if (remaining > 0 && (stack_est < 2 || deep || $urandom_range(0, 1) == 1)) begin
        expr_q.push_back(digit($urandom_range(0, 9)));
        remaining--;
        stack_est++;
      end else begin
        expr_q.push_back(rand_oper());
        stack_est--;
      end
    end
    expr_q.push_back(CH_END);
  endtask

  // arbitrary mix of digits, operators and other bytes, then an end
  task automatic build_noise();
    int len;
    int pick;
    expr_q.delete();
    len = $urandom_range(1, 10);
    repeat (len) begin
      pick = $urandom_range(0, 9);
      if (pick < 4)
        expr_q.push_back(digit($urandom_range(0, 9)));
      else if (pick < 7)
        expr_q.push_back(rand_oper());
      else
        expr_q.push_back(8'($urandom_range(1, 255)));
    end
    expr_q.push_back(CH_END);
  endtask

  task automatic build_random();
    if ($urandom_range(0, 99) < 70) begin
      if ($urandom_range(0, 9) == 0)
        build_wellformed($urandom_range(7, 20), 1'b0);
      else
        build_wellformed($urandom_range(1, 6), 1'b0);
    end else begin
      build_noise();
    end
  endtask

  // stop offering, wait for every result, then let the last op finish
  task automatic drain_block();
    in_ch.valid <= 1'b0;
    @(posedge clk);
    while (pending_results != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_limit(input logic [7:0] lim);
    cfg_we    <= 1'b1;
    cfg_wdata <= lim;
    @(posedge clk);
    cfg_we    <= 1'b0;
    limits_applied++;
  endtask

  task automatic run_phase(input logic [7:0] lim, input int budget, input bit deep);
    int first;
    drain_block();
    set_limit(lim);
    first = symbols_sent;
    if (deep) begin
      build_wellformed(DEEP_OPERANDS, 1'b1);
      send_expr();
    end
    while (symbols_sent - first < budget) begin
      build_random();
      send_expr();
    end
  endtask

  // main sequence
  initial begin
    in_ch.valid    = 1'b0;
    in_ch.symbol   = CH_END;
    cfg_we         = 1'b0;
    cfg_wdata      = '0;
    rst_n          = 1'b0;
    no_idle        = 1'b0;
    hold_asks      = 0;
    symbols_sent   = 0;
    limits_applied = 0;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // directed cases under the reset limit
    expr_q = '{
      CH_END,                                          // end on empty stack
      digit(9), digit(9), CH_TIMES, CH_END,            // product wraps the byte
      digit(1), digit(2), CH_MINUS, CH_END,            // negative difference
      digit(7), digit(0), CH_SLASH, CH_END,            // divide by zero
      digit(0), digit(7), CH_MINUS, digit(2), CH_SLASH, CH_END, // rounds toward zero
      CH_PLUS, CH_END,                                 // operator on empty stack
      SYM_TOP_BYTE, SYM_LOW_BYTE,                      // skipped bytes
      digit(5), digit(5), digit(5), CH_PLUS, CH_END    // one entry left behind
    };
    send_expr();

    // random phases across limit settings
    run_phase(8'd3, 80, 1'b0);
    run_phase(8'd1, 80, 1'b0);
    run_phase(8'd0, 60, 1'b0);
    run_phase(8'd200, 80, 1'b1);
    run_phase(8'd255, 60, 1'b0);
    no_idle = 1'b1;
    run_phase(8'd2, 80, 1'b0);
    no_idle = 1'b0;
    hold_asks++;
    run_phase(8'd128, 100, 1'b0);
    run_phase(8'($urandom_range(1, 128)), 80, 1'b0);
    run_phase(LIMIT_RESET, 80, 1'b0);
    drain_block();

    $display("covered %0d symbols under %0d limit writes, %0d results compared",
             symbols_sent, limits_applied, results_checked);
    $display("flags raised in expected results: underflow %b overflow %b divide-by-zero %b",
             flags_hit[0], flags_hit[1], flags_hit[2]);
    if (mismatch_count == 0 && pending_results == 0) begin
      $display("tb_postfix_digit_evaluator: done, clean");
    end else begin
      $display("%0d mismatches, %0d results outstanding", mismatch_count, pending_results);
      $display("tb_postfix_digit_evaluator: done, errors");
    end
    $finish;
  end

endmodule
